// ===== rtl/cdq_pkg.sv =====
// cdq_pkg: widths, request codes, status codes and controller command type
// for the circular deque; no dependencies
package cdq_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 3;
  localparam int STAT_W        = 2;

  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NOP        = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_en;
    logic show;
  } cdq_cmd_t;

endpackage

// ===== rtl/cdq_ram.sv =====
// cdq_ram: generic single-write, dual-read RAM with registered read data
// no dependencies
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/cdq_ctrl.sv =====
// cdq_ctrl: request sequencer for the circular deque
// depends on cdq_pkg for the command type
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output cdq_pkg::cdq_cmd_t cmd
);
  import cdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_READ;
      S_READ: state_next = S_OUT;
      S_OUT: begin
        state_next = start ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy      = (state == S_EXEC) || (state == S_READ);
  assign cmd.load  = start && !busy;
  assign cmd.exec  = (state == S_EXEC);
  assign cmd.rd_en = (state == S_READ);
  assign cmd.show  = (state == S_OUT);

endmodule

// ===== rtl/cdq_datapath.sv =====
// cdq_datapath: head, tail and count registers, entry store and result muxing
// depends on cdq_pkg and cdq_ram
module cdq_datapath #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cdq_pkg::cdq_cmd_t                  cmd,
  input  logic [cdq_pkg::FUNC_W-1:0]         func,
  input  logic signed [cdq_pkg::DATA_W-1:0]  data_value,
  output logic signed [cdq_pkg::DATA_W-1:0]  front_value,
  output logic signed [cdq_pkg::DATA_W-1:0]  rear_value,
  output logic                               is_empty,
  output logic                               is_full,
  output logic [cdq_pkg::STAT_W-1:0]         status,
  output logic [$clog2(DEPTH+1)-1:0]         occupancy
);
  import cdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [FUNC_W-1:0] func_r;
  logic [DATA_W-1:0] data_r;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  count;
  logic [STAT_W-1:0] status_r;

  logic [IDX_W-1:0]  head_next;
  logic [IDX_W-1:0]  tail_next;
  logic [CNT_W-1:0]  count_next;
  logic [STAT_W-1:0] status_next;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  head_dec;
  logic [IDX_W-1:0]  tail_inc;
  logic [IDX_W-1:0]  tail_dec;
  logic              is_push;
  logic              is_pop;
  logic              q_full;
  logic              q_empty;
  logic [DATA_W-1:0] rd_front;
  logic [DATA_W-1:0] rd_rear;

  assign head_inc = (head == IDX_LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? IDX_LAST : head - 1'b1;
  assign tail_inc = (tail == IDX_LAST) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? IDX_LAST : tail - 1'b1;

  assign is_push = (func_r == FUNC_PUSH_FRONT) || (func_r == FUNC_PUSH_REAR);
  assign is_pop  = (func_r == FUNC_POP_FRONT) || (func_r == FUNC_POP_REAR);
  assign q_full  = (count == CNT_FULL);
  assign q_empty = (count == '0);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    status_next = STAT_OK;
    we          = 1'b0;
    waddr       = '0;
    if (is_push) begin
      if (q_full) begin
        status_next = STAT_OVERFLOW;
      end else if (q_empty) begin
        head_next  = '0;
        tail_next  = '0;
        count_next = CNT_W'(1);
        we         = 1'b1;
      end else if (func_r == FUNC_PUSH_FRONT) begin
        head_next  = head_dec;
        waddr      = head_dec;
        count_next = count + 1'b1;
        we         = 1'b1;
      end else begin
        tail_next  = tail_inc;
        waddr      = tail_inc;
        count_next = count + 1'b1;
        we         = 1'b1;
      end
    end else if (is_pop) begin
      if (q_empty) begin
        status_next = STAT_UNDERFLOW;
      end else if (count == CNT_W'(1)) begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
      end else begin
        if (func_r == FUNC_POP_FRONT) begin
          head_next = head_inc;
        end else begin
          tail_next = tail_dec;
        end
        count_next = count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      data_r <= data_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      status_r <= STAT_OK;
    end else if (cmd.exec) begin
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      status_r <= status_next;
    end
  end

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (cmd.exec && we),
    .waddr   (waddr),
    .wdata   (data_r),
    .re      (cmd.rd_en),
    .raddr_a (head),
    .raddr_b (tail),
    .rdata_a (rd_front),
    .rdata_b (rd_rear)
  );

  // empty queue shows all ones at both ends
  assign front_value = q_empty ? '1 : rd_front;
  assign rear_value  = q_empty ? '1 : rd_rear;
  assign is_empty    = q_empty;
  assign is_full     = q_full;
  assign status      = status_r;
  assign occupancy   = count;

endmodule

// ===== rtl/circular_deque.sv =====
// circular_deque: an accepted request passes through the EXEC, READ and OUT states; done is high in OUT.
// a new request is taken while idle or, at the earliest, in the cycle done is high; none is taken while busy.
// each request is executed on the head, tail and count registers, then the entry RAM is read with registered read data.
// synchronous reset empties the queue; the entry RAM contents are not cleared.
// done lasts exactly one cycle and the receiver cannot hold it off.
// depends on cdq_pkg, cdq_ctrl, cdq_datapath and cdq_ram
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [cdq_pkg::FUNC_W-1:0]         func,
  input  logic signed [cdq_pkg::DATA_W-1:0]  data_value,
  output logic                               done,
  output logic signed [cdq_pkg::DATA_W-1:0]  front_value,
  output logic signed [cdq_pkg::DATA_W-1:0]  rear_value,
  output logic                               is_empty,
  output logic                               is_full,
  output logic [cdq_pkg::STAT_W-1:0]         status,
  output logic [$clog2(DEPTH+1)-1:0]         occupancy
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .data_value  (data_value),
    .front_value (front_value),
    .rear_value  (rear_value),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .status      (status),
    .occupancy   (occupancy)
  );

  assign done = cmd.show;

endmodule
